// File: src/dbc_pkg.sv
// Shared types and codes for the disk block cache tag engine.
package dbc_pkg;

  typedef enum logic [1:0] {
    FN_ACQUIRE = 2'd0,
    FN_RELEASE = 2'd1,
    FN_PIN     = 2'd2,
    FN_NONE    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_UNDER = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP_RD,
    S_OP_MOD,
    S_SCAN,
    S_DRAIN,
    S_ALLOC,
    S_DONE
  } state_t;

  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef struct packed {
    logic [15:0] dev;
    logic [31:0] blk;
    logic [31:0] stamp;
    logic [7:0]  count;
    logic        dvalid;
    logic        assigned;
  } entry_t;

endpackage

// File: src/disk_block_cache_tag_engine_unit.sv
// Top level of the disk block cache tag engine: slot memory and its sequencer.
// Acquire: a scan of every slot, one slot read per cycle, then drain and allocate steps;
//   the next item is taken only after the previous result is loaded into the output register.
// Release / pin: read, modify-write and result steps; no new item is taken before the result step.
// Function code 3 and an out-of-range slot on release or pin go straight to the result step.
// Reset (rst, synchronous) clears control and the per-slot written bits; an unwritten
//   slot reads as all zero, so no clearing pass is run.
module disk_block_cache_tag_engine_unit
  import dbc_pkg::*;
#(
  parameter int ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] func, [17:2] dev, [49:18] block_number, [54:50] entry_index, [86:55] now
  input  logic [87:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] slot, [5] hit, [6] need_read, [8:7] status
  output logic [15:0] m_axis_tdata
);

  localparam int IW = $clog2(ENTRIES);

  state_t state, state_next;

  // latched request
  func_t       func_q;
  logic [15:0] dev_q;
  logic [31:0] blk_q;
  logic [4:0]  idx_q;
  logic [31:0] now_q;

  // result
  logic [4:0] res_slot;
  logic       res_hit;
  logic       res_need;
  status_t    res_status;

  // slot memory
  entry_t          mem [ENTRIES];
  logic [ENTRIES-1:0] written;
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  entry_t          mem_wdata;
  logic [IW-1:0]   mem_raddr;
  entry_t          rd_rec;
  logic            rd_ok;
  entry_t          rd_eff;

  // scan bookkeeping
  logic [IW-1:0] cnt;
  logic          chk_v;
  logic [IW-1:0] chk_idx;
  logic          hit_found;
  logic [IW-1:0] hit_idx;
  logic [7:0]    hit_count;
  logic          hit_dv;
  logic [31:0]   hit_stamp;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic [31:0]   free_stamp;

  logic          in_xfer;
  logic          out_free;
  func_t         in_func;
  logic [4:0]    in_idx;
  logic          in_range;
  logic          op_range;
  logic [IW-1:0] op_addr;
  logic          match;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign in_func  = func_t'(s_axis_tdata[1:0]);
  assign in_idx   = s_axis_tdata[54:50];
  assign in_range = 32'(in_idx) < ENTRIES;
  assign op_range = 32'(idx_q) < ENTRIES;
  assign op_addr  = IW'(idx_q);
  assign rd_eff   = rd_ok ? rd_rec : '0;
  assign match    = rd_eff.assigned && (rd_eff.dev == dev_q) && (rd_eff.blk == blk_q);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if (in_func == FN_ACQUIRE) state_next = S_SCAN;
          else if (in_func == FN_NONE || !in_range) state_next = S_DONE;
          else state_next = S_OP_RD;
        end
      end
      S_OP_RD:  state_next = S_OP_MOD;
      S_OP_MOD: state_next = S_DONE;
      S_SCAN:   if (cnt == IW'(ENTRIES - 1)) state_next = S_DRAIN;
      S_DRAIN:  state_next = S_ALLOC;
      S_ALLOC:  state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // control outputs and memory write
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = op_addr;
    mem_wdata     = rd_eff;
    mem_raddr     = op_addr;
    unique case (state)
      S_IDLE: s_axis_tready = 1'b1;
      S_OP_MOD: begin
        if (func_q == FN_RELEASE) begin
          mem_we          = rd_eff.count != 8'd0;
          mem_wdata.count = rd_eff.count - 8'd1;
        end else begin
          mem_we = 1'b1;
          if (rd_eff.count != COUNT_MAX) mem_wdata.count = rd_eff.count + 8'd1;
        end
      end
      S_SCAN: mem_raddr = cnt;
      S_ALLOC: begin
        if (hit_found) begin
          mem_we    = 1'b1;
          mem_waddr = hit_idx;
          mem_wdata = '{dev: dev_q, blk: blk_q, stamp: hit_stamp,
                        count: (hit_count != COUNT_MAX) ? hit_count + 8'd1 : hit_count,
                        dvalid: 1'b1, assigned: 1'b1};
        end else if (free_found) begin
          mem_we    = 1'b1;
          mem_waddr = free_idx;
          mem_wdata = '{dev: dev_q, blk: blk_q, stamp: now_q, count: 8'd1,
                        dvalid: 1'b1, assigned: 1'b1};
        end
      end
      default: ;
    endcase
  end

  // slot memory, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_rec <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_ok   <= 1'b0;
    end else begin
      if (mem_we) written[mem_waddr] <= 1'b1;
      rd_ok <= written[mem_raddr];
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      chk_v         <= 1'b0;
      hit_found     <= 1'b0;
      free_found    <= 1'b0;
      m_axis_tvalid <= 1'b0;
      cnt           <= '0;
    end else begin
      state <= state_next;
      chk_v <= (state == S_SCAN);

      if (in_xfer) begin
        cnt        <= '0;
        hit_found  <= 1'b0;
        free_found <= 1'b0;
      end else if (state == S_SCAN) begin
        cnt <= cnt + IW'(1);
      end

      // one slot checked per cycle, first match and oldest free slot kept
      if (chk_v) begin
        if (match && !hit_found) hit_found <= 1'b1;
        if (rd_eff.count == 8'd0 && (!free_found || rd_eff.stamp < free_stamp))
          free_found <= 1'b1;
      end

      if (state == S_DONE && out_free) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    chk_idx <= cnt;
    if (chk_v) begin
      if (match && !hit_found) begin
        hit_idx   <= chk_idx;
        hit_count <= rd_eff.count;
        hit_dv    <= rd_eff.dvalid;
        hit_stamp <= rd_eff.stamp;
      end
      if (rd_eff.count == 8'd0 && (!free_found || rd_eff.stamp < free_stamp)) begin
        free_idx   <= chk_idx;
        free_stamp <= rd_eff.stamp;
      end
    end

    if (in_xfer) begin
      func_q     <= in_func;
      dev_q      <= s_axis_tdata[17:2];
      blk_q      <= s_axis_tdata[49:18];
      idx_q      <= in_idx;
      now_q      <= s_axis_tdata[86:55];
      res_slot   <= (in_func == FN_NONE) ? 5'd0 : in_idx;
      res_hit    <= 1'b0;
      res_need   <= 1'b0;
      res_status <= ST_OK;
    end

    if (state == S_OP_MOD && op_range && func_q == FN_RELEASE && rd_eff.count == 8'd0)
      res_status <= ST_UNDER;

    if (state == S_ALLOC) begin
      if (hit_found) begin
        res_slot <= 5'(hit_idx);
        res_hit  <= 1'b1;
        res_need <= !hit_dv;
      end else if (free_found) begin
        res_slot <= 5'(free_idx);
        res_need <= 1'b1;
      end else begin
        res_slot   <= 5'd0;
        res_status <= ST_FULL;
      end
    end

    if (state == S_DONE && out_free)
      m_axis_tdata <= {7'd0, res_status, res_need, res_hit, res_slot};
  end

endmodule

// File: tb/tb_dbc_scoreboard_pkg.sv
// Scoreboard for the disk block cache tag engine: slot-state predictor and result checker.
`timescale 1ns / 100ps
package tb_dbc_scoreboard_pkg;
  import dbc_pkg::*;

  localparam int SLOTS = 32;

  typedef struct packed {
    logic [4:0] slot;
    logic       hit;
    logic       need_read;
    status_t    status;
  } slot_result_t;

  class slot_tag_scoreboard;
    logic [15:0]  tag_dev   [SLOTS];
    logic [31:0]  tag_blk   [SLOTS];
    logic [7:0]   refs      [SLOTS];
    logic [31:0]  stamp     [SLOTS];
    bit           valid     [SLOTS];
    bit           in_use    [SLOTS];
    slot_result_t expected_results[$];
    int unsigned  errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        tag_dev[i] = '0;
        tag_blk[i] = '0;
        refs[i]    = '0;
        stamp[i]   = '0;
        valid[i]   = 1'b0;
        in_use[i]  = 1'b0;
      end
      errors = 0;
    endfunction

    // Hit bumps the count; miss retags the free slot with the oldest stamp, lowest index first.
    function slot_result_t lookup_or_allocate(logic [15:0] dev, logic [31:0] blk,
                                              logic [31:0] now);
      slot_result_t r;
      int           pick;
      bit           found;
      r     = '0;
      pick  = 0;
      found = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        if (in_use[i] && tag_dev[i] == dev && tag_blk[i] == blk) begin
          if (refs[i] < COUNT_MAX) refs[i] = refs[i] + 8'd1;
          r.slot      = 5'(i);
          r.hit       = 1'b1;
          r.need_read = !valid[i];
          valid[i]    = 1'b1;
          return r;
        end
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (refs[i] == 0 && (!found || stamp[i] < stamp[pick])) begin
          pick  = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        r.status = ST_FULL;
        return r;
      end
      tag_dev[pick] = dev;
      tag_blk[pick] = blk;
      refs[pick]    = 8'd1;
      stamp[pick]   = now;
      in_use[pick]  = 1'b1;
      valid[pick]   = 1'b1;
      r.slot        = 5'(pick);
      r.need_read   = 1'b1;
      return r;
    endfunction

    function void note_request(func_t fn, logic [15:0] dev, logic [31:0] blk,
                               logic [4:0] idx, logic [31:0] now);
      slot_result_t r;
      r = '0;
      case (fn)
        FN_ACQUIRE: r = lookup_or_allocate(dev, blk, now);
        FN_NONE: ;
        default: begin
          r.slot = idx;
          if (int'(idx) < SLOTS) begin
            if (fn == FN_RELEASE) begin
              if (refs[idx] == 0) r.status = ST_UNDER;
              else refs[idx] = refs[idx] - 8'd1;
            end else if (refs[idx] < COUNT_MAX) begin
              refs[idx] = refs[idx] + 8'd1;
            end
          end
        end
      endcase
      expected_results.push_back(r);
    endfunction

    function void check_response(logic [15:0] d);
      slot_result_t e;
      if (expected_results.size() == 0) begin
        $error("result with no request pending: tdata %h", d);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (d[4:0] !== e.slot) begin
        $error("slot: expected %0d, actual %0d", e.slot, d[4:0]);
        errors++;
      end
      if (d[5] !== e.hit) begin
        $error("hit: expected %0d, actual %0d", e.hit, d[5]);
        errors++;
      end
      if (d[6] !== e.need_read) begin
        $error("need_read: expected %0d, actual %0d", e.need_read, d[6]);
        errors++;
      end
      if (d[8:7] !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, d[8:7]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function logic [7:0] count_of(int i);
      return refs[i];
    endfunction
  endclass

endpackage

// File: tb/tb_disk_block_cache_tag_engine_unit.sv
// Top-level testbench for the disk block cache tag engine: stimulus, stalls and end of run.
`timescale 1ns / 100ps
module tb_disk_block_cache_tag_engine_unit;
  import dbc_pkg::*;
  import tb_dbc_scoreboard_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // [1:0] func, [17:2] dev, [49:18] block_number, [54:50] entry_index, [86:55] now
  logic [87:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [4:0] slot, [5] hit, [6] need_read, [8:7] status
  logic [15:0] m_axis_tdata;

  slot_tag_scoreboard tag_ledger = new();

  int unsigned send_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned items_sent;
  logic [31:0] tick;
  logic [15:0] pool_dev [8];
  logic [31:0] pool_blk [8];

  disk_block_cache_tag_engine_unit #(
    .ENTRIES(SLOTS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb_disk_block_cache_tag_engine_unit NOT OK");
    $finish;
  end

  always @(negedge clk) begin
    m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) tag_ledger.check_response(m_axis_tdata);
  end

  task automatic send_item(func_t fn, logic [15:0] dev, logic [31:0] blk,
                           logic [4:0] idx, logic [31:0] now);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {1'b0, now, idx, blk, dev, fn};
    do @(posedge clk); while (!s_axis_tready);
    tag_ledger.note_request(fn, dev, blk, idx, now);
    items_sent++;
  endtask

  task automatic acquire_tag(logic [15:0] dev, logic [31:0] blk);
    tick = tick + 32'($urandom_range(1, 50));
    send_item(FN_ACQUIRE, dev, blk, 5'($urandom), tick);
  endtask

  // Release a slot that holds a reference if there is one, so counts stay bounded.
  task automatic release_held();
    int         start;
    logic [4:0] s;
    start = $urandom_range(SLOTS - 1);
    s     = 5'(start);
    for (int i = 0; i < SLOTS; i++) begin
      if (tag_ledger.count_of((start + i) % SLOTS) != 0) begin
        s = 5'((start + i) % SLOTS);
        break;
      end
    end
    send_item(FN_RELEASE, 16'($urandom), $urandom, s, $urandom);
  endtask

  // Acquire fresh tags until the cache runs out of free slots, then release every slot with a count below 100 to zero.
  task automatic fill_and_drain();
    repeat (36) acquire_tag(16'($urandom), $urandom);
    for (int i = 0; i < SLOTS; i++) begin
      while (tag_ledger.count_of(i) != 0 && tag_ledger.count_of(i) < 8'd100)
        send_item(FN_RELEASE, 16'($urandom), $urandom, 5'(i), $urandom);
    end
  endtask

  task automatic run_phase(int unsigned n, int unsigned idle_pct, int unsigned stall_pct);
    int unsigned target;
    int unsigned r;
    int unsigned k;
    send_idle_pct  = idle_pct;
    sink_stall_pct = stall_pct;
    target         = items_sent + n;
    while (items_sent < target) begin
      r = $urandom_range(99);
      k = $urandom_range(7);
      if (r < 6) begin
        fill_and_drain();
      end else if (r < 76) begin
        r = $urandom_range(99);
        if (r < 45) acquire_tag(pool_dev[k], pool_blk[k]);
        else if (r < 90) release_held();
        else send_item(FN_PIN, 16'($urandom), $urandom, 5'($urandom), $urandom);
      end else if (r < 90) begin
        acquire_tag(16'($urandom), $urandom);
      end else begin
        send_item(func_t'($urandom_range(3)), 16'($urandom), $urandom, 5'($urandom),
                  $urandom);
      end
    end
  endtask

  initial begin
    logic [15:0] dev_base;
    logic [31:0] blk_base;
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    items_sent     = 0;
    tick           = 32'd100;
    dev_base       = 16'($urandom);
    blk_base       = $urandom;
    // half the pool shares a device and differs in one block bit, to probe tag compare
    for (int k = 0; k < 8; k++) begin
      pool_dev[k] = (k < 4) ? dev_base : 16'($urandom);
      pool_blk[k] = (k < 4) ? (blk_base ^ (32'd1 << (k * 8 + 3))) : $urandom;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_item(FN_ACQUIRE, 16'h0000, 32'h0000_0000, 5'd0,  32'h0000_0000);
    send_item(FN_ACQUIRE, 16'hFFFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
    send_item(FN_ACQUIRE, 16'h0000, 32'h0000_0000, 5'd0,  32'h0000_0005);
    send_item(FN_ACQUIRE, 16'h0001, 32'h0000_0000, 5'd0,  32'h0000_0006);
    send_item(FN_ACQUIRE, 16'h0000, 32'h8000_0000, 5'd0,  32'h0000_0007);
    send_item(FN_NONE,    16'hFFFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
    send_item(FN_RELEASE, 16'h0000, 32'h0000_0000, 5'd0,  32'h0000_0000);
    send_item(FN_RELEASE, 16'h0000, 32'h0000_0000, 5'd0,  32'h0000_0000);
    send_item(FN_RELEASE, 16'h0000, 32'h0000_0000, 5'd0,  32'h0000_0000);
    // untagged slot: count still moves, underflow still flagged
    send_item(FN_RELEASE, 16'hFFFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
    send_item(FN_PIN,     16'hFFFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
    send_item(FN_RELEASE, 16'h0000, 32'h0000_0000, 5'd31, 32'h0000_0000);
    send_item(FN_PIN,     16'h0000, 32'h0000_0000, 5'd1,  32'h0000_0000);
    send_item(FN_RELEASE, 16'h0000, 32'h0000_0000, 5'd1,  32'h0000_0000);
    send_item(FN_RELEASE, 16'h0000, 32'h0000_0000, 5'd1,  32'h0000_0000);
    // hit on a tagged slot whose count has dropped to zero
    send_item(FN_ACQUIRE, 16'h0000, 32'h0000_0000, 5'd0,  32'h0000_0010);
    send_item(FN_ACQUIRE, 16'h1234, 32'h5678_9ABC, 5'd0,  32'h0000_0000);
    send_item(FN_ACQUIRE, 16'hFFFF, 32'hFFFF_FFFF, 5'd0,  32'h0000_0020);
    send_item(FN_RELEASE, 16'h0000, 32'h0000_0000, 5'd2,  32'h0000_0000);
    send_item(FN_RELEASE, 16'h0000, 32'h0000_0000, 5'd3,  32'h0000_0000);
    send_item(FN_NONE,    16'h0000, 32'h0000_0000, 5'd0,  32'h0000_0000);

    // count saturation; the slot keeps a high count for the rest of the run
    repeat (258) send_item(FN_PIN, 16'($urandom), $urandom, 5'd5, $urandom);
    send_item(FN_RELEASE, 16'($urandom), $urandom, 5'd5, $urandom);

    run_phase(95, 0, 0);
    run_phase(95, 56, 0);
    run_phase(95, 0, 56);
    run_phase(95, 6, 6);

    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (tag_ledger.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (tag_ledger.errors == 0) begin
      $display("tb_disk_block_cache_tag_engine_unit OK");
    end else begin
      $display("tb_disk_block_cache_tag_engine_unit NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
src/dbc_pkg.sv
src/disk_block_cache_tag_engine_unit.sv
tb/tb_dbc_scoreboard_pkg.sv
tb/tb_disk_block_cache_tag_engine_unit.sv
